// ----- src/lzwd_pkg.sv -----
// Shared types and constants of the LZW variable-width decoder.
// Used by lzwd_ctrl, lzwd_dp and lzw_variable_width_decoder; no dependencies.
package lzwd_pkg;

  // Dictionary geometry
  localparam int CODE_W     = 12;
  localparam int TABLE_SIZE = 1 << CODE_W;
  localparam int LVL_W      = CODE_W + 1;

  // Datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_PUSH  = 4'd1;
  localparam logic [3:0] OP_ADV   = 4'd2;
  localparam logic [3:0] OP_RD1   = 4'd3;
  localparam logic [3:0] OP_RD2   = 4'd4;
  localparam logic [3:0] OP_WALK  = 4'd5;
  localparam logic [3:0] OP_WALK2 = 4'd6;
  localparam logic [3:0] OP_POP   = 4'd7;
  localparam logic [3:0] OP_POP2  = 4'd8;

  // Outcome of one advance step
  localparam logic [2:0] ADV_CONT = 3'd0;
  localparam logic [2:0] ADV_OK   = 3'd1;
  localparam logic [2:0] ADV_ADD  = 3'd2;
  localparam logic [2:0] ADV_NEED = 3'd3;
  localparam logic [2:0] ADV_END  = 3'd4;
  localparam logic [2:0] ADV_ERR  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEED = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  typedef struct packed {
    logic [3:0] op;
  } lzwd_cmd_t;

  typedef struct packed {
    logic       stack_empty;
    logic       walk_done;
    logic [2:0] adv_kind;
    logic [7:0] byte_val;
  } lzwd_stat_t;

endpackage

// ----- src/lzwd_dp.sv -----
// Datapath of the LZW decoder: bit buffer, dictionary memories, string stack.
// Depends on lzwd_pkg; driven by commands from lzwd_ctrl.
module lzwd_dp import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lzwd_cmd_t  cmd,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output lzwd_stat_t stat
);

  localparam logic [2:0] PH_AWAIT = 3'd0;
  localparam logic [2:0] PH_AFTER = 3'd1;
  localparam logic [2:0] PH_RUN   = 3'd2;
  localparam logic [2:0] PH_ENDED = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  localparam logic [CODE_W-1:0] CODE_CLEAR = CODE_W'(256);
  localparam logic [CODE_W-1:0] CODE_EOI   = CODE_W'(257);
  localparam logic [CODE_W-1:0] CODE_FIRST = CODE_W'(258);
  localparam logic [LVL_W-1:0]  NF_RESET   = LVL_W'(258);
  localparam logic [LVL_W-1:0]  NF_FULL    = LVL_W'(TABLE_SIZE);
  localparam logic [3:0]        W_INIT     = 4'd9;
  localparam logic [3:0]        W_MAX      = 4'(CODE_W);

  // Dictionary and stack memories
  logic [CODE_W-1:0] pfx_mem [TABLE_SIZE];
  logic [7:0]        sfx_mem [TABLE_SIZE];
  logic [7:0]        fb_mem  [TABLE_SIZE];
  logic [7:0]        stk_mem [TABLE_SIZE];

  logic [31:0]       bitbuf_r, bitbuf_nxt;
  logic [5:0]        nbits_r, nbits_nxt;
  logic [3:0]        width_r, width_nxt;
  logic [LVL_W-1:0]  nf_r, nf_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic              fin_r, fin_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] src_r, src_nxt;
  logic [7:0]        sfx_r, sfx_nxt;
  logic [7:0]        byte_r, byte_nxt;

  logic [CODE_W-1:0] pfx_rd_r;
  logic [7:0]        sfx_rd_r, fb_rd_r, stk_rd_r;

  logic [31:0]       shifted;
  logic [CODE_W:0]   mask_w;
  logic [CODE_W-1:0] code_c, src_c, fb_addr;
  logic [LVL_W-1:0]  nf_inc, nf_lim;
  logic [7:0]        fp_byte, stk_wdata;
  logic              tbl_we, stk_we;
  logic [2:0]        adv_kind;

  // Extract the next code, MSB first
  assign shifted = bitbuf_r >> (nbits_r - {2'b00, width_r});
  assign mask_w  = ((CODE_W+1)'(1) << width_r) - (CODE_W+1)'(1);
  assign code_c  = shifted[CODE_W-1:0] & mask_w[CODE_W-1:0];
  assign src_c   = ({1'b0, code_c} < nf_r) ? code_c : prev_r;
  assign fb_addr = (cmd.op == OP_ADV) ? src_c : prev_r;
  assign fp_byte = (prev_r < CODE_CLEAR) ? prev_r[7:0] : fb_rd_r;
  assign nf_inc  = nf_r + LVL_W'(1);
  assign nf_lim  = (LVL_W'(1) << width_r) - LVL_W'(1);

  // Next-state logic per command
  always_comb begin
    bitbuf_nxt = bitbuf_r;
    nbits_nxt  = nbits_r;
    width_nxt  = width_r;
    nf_nxt     = nf_r;
    prev_nxt   = prev_r;
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    level_nxt  = level_r;
    cur_nxt    = cur_r;
    code_nxt   = code_r;
    src_nxt    = src_r;
    sfx_nxt    = sfx_r;
    byte_nxt   = byte_r;
    tbl_we     = 1'b0;
    stk_we     = 1'b0;
    stk_wdata  = cur_r[7:0];
    adv_kind   = ADV_NEED;

    // Classify the advance step
    if (phase_r == PH_ENDED) begin
      adv_kind = ADV_END;
    end else if (phase_r == PH_ERROR) begin
      adv_kind = ADV_ERR;
    end else if (nbits_r < {2'b00, width_r}) begin
      adv_kind = fin_r ? ADV_END : ADV_NEED;
    end else if (phase_r == PH_AWAIT) begin
      adv_kind = (code_c != CODE_CLEAR) ? ADV_ERR : ADV_CONT;
    end else if (code_c == CODE_CLEAR) begin
      adv_kind = ADV_CONT;
    end else if (code_c == CODE_EOI) begin
      adv_kind = ADV_END;
    end else if (phase_r == PH_AFTER) begin
      adv_kind = (code_c >= CODE_FIRST) ? ADV_ERR : ADV_OK;
    end else begin
      adv_kind = ({1'b0, code_c} > nf_r) ? ADV_ERR : ADV_ADD;
    end

    case (cmd.op)
      OP_PUSH: begin
        if (!fin_r) begin
          if (nbits_r > 6'd24) begin
            if (phase_r < PH_ENDED) phase_nxt = PH_ERROR;
          end else begin
            bitbuf_nxt = {bitbuf_r[23:0], in_byte};
            nbits_nxt  = nbits_r + 6'd8;
            fin_nxt    = in_last;
          end
        end
      end
      OP_ADV: begin
        if (phase_r < PH_ENDED && nbits_r < {2'b00, width_r}) begin
          if (fin_r) phase_nxt = PH_ENDED;
        end else if (phase_r < PH_ENDED) begin
          nbits_nxt = nbits_r - {2'b00, width_r};
          case (adv_kind)
            ADV_CONT: begin
              nf_nxt    = NF_RESET;
              width_nxt = W_INIT;
              phase_nxt = PH_AFTER;
            end
            ADV_END: phase_nxt = PH_ENDED;
            ADV_ERR: phase_nxt = PH_ERROR;
            ADV_OK: begin
              cur_nxt   = code_c;
              prev_nxt  = code_c;
              phase_nxt = PH_RUN;
            end
            ADV_ADD: begin
              code_nxt = code_c;
              src_nxt  = src_c;
            end
            default: ;
          endcase
        end
      end
      OP_RD1: begin
        sfx_nxt = (src_r < CODE_CLEAR) ? src_r[7:0] : fb_rd_r;
      end
      OP_RD2: begin
        // Add the new entry unless the table is full
        if (nf_r < NF_FULL) begin
          tbl_we = 1'b1;
          nf_nxt = nf_inc;
          if (width_r < W_MAX && nf_inc == nf_lim) width_nxt = width_r + 4'd1;
        end
        prev_nxt = code_r;
        cur_nxt  = code_r;
      end
      OP_WALK: begin
        if (cur_r < CODE_FIRST) begin
          stk_we    = 1'b1;
          level_nxt = level_r + LVL_W'(1);
        end
      end
      OP_WALK2: begin
        stk_we    = 1'b1;
        stk_wdata = sfx_rd_r;
        level_nxt = level_r + LVL_W'(1);
        cur_nxt   = pfx_rd_r;
      end
      OP_POP:  level_nxt = level_r - LVL_W'(1);
      OP_POP2: byte_nxt  = stk_rd_r;
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitbuf_r <= '0;
      nbits_r  <= '0;
      width_r  <= W_INIT;
      nf_r     <= NF_RESET;
      prev_r   <= '0;
      phase_r  <= PH_AWAIT;
      fin_r    <= 1'b0;
      level_r  <= '0;
    end else begin
      bitbuf_r <= bitbuf_nxt;
      nbits_r  <= nbits_nxt;
      width_r  <= width_nxt;
      nf_r     <= nf_nxt;
      prev_r   <= prev_nxt;
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      level_r  <= level_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    code_r <= code_nxt;
    src_r  <= src_nxt;
    sfx_r  <= sfx_nxt;
    byte_r <= byte_nxt;
  end

  // Dictionary memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      pfx_mem[nf_r[CODE_W-1:0]] <= prev_r;
      sfx_mem[nf_r[CODE_W-1:0]] <= sfx_r;
      fb_mem[nf_r[CODE_W-1:0]]  <= fp_byte;
    end
    pfx_rd_r <= pfx_mem[cur_r];
    sfx_rd_r <= sfx_mem[cur_r];
    fb_rd_r  <= fb_mem[fb_addr];
  end

  // String stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[level_r[CODE_W-1:0]] <= stk_wdata;
    stk_rd_r <= stk_mem[level_r[CODE_W-1:0] - CODE_W'(1)];
  end

  assign stat.stack_empty = (level_r == '0);
  assign stat.walk_done   = (cur_r < CODE_FIRST);
  assign stat.adv_kind    = adv_kind;
  assign stat.byte_val    = byte_r;

endmodule

// ----- src/lzwd_ctrl.sv -----
// Controller of the LZW decoder: sequences requests and holds the result register.
// Depends on lzwd_pkg; commands lzwd_dp.
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_end,
  input  lzwd_stat_t stat,
  output lzwd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_WALK2 = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_POP2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       look_r, look_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic       res_end_r, res_end_nxt;
  logic       ov_r, ov_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic       oend_r, oend_nxt;
  logic [7:0] obyte_r, obyte_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence one transaction
  always_comb begin
    state_nxt   = state_r;
    look_nxt    = look_r;
    res_st_nxt  = res_st_r;
    res_end_nxt = res_end_r;
    ov_nxt      = ov_r && !out_ready;
    ost_nxt     = ost_r;
    oend_nxt    = oend_r;
    obyte_nxt   = obyte_r;
    cmd.op      = OP_NONE;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_func) begin
            cmd.op = OP_PUSH;
          end else begin
            look_nxt  = 1'b0;
            state_nxt = stat.stack_empty ? S_ADV : S_POP;
          end
        end
      end
      S_ADV: begin
        cmd.op = OP_ADV;
        case (stat.adv_kind)
          ADV_CONT: state_nxt = S_ADV;
          ADV_OK:   state_nxt = S_WALK;
          ADV_ADD:  state_nxt = S_RD1;
          default: begin
            // Stop: report status, or flag end after a look-ahead
            state_nxt = S_DONE;
            if (look_r) begin
              res_st_nxt  = ST_OK;
              res_end_nxt = (stat.adv_kind == ADV_END);
            end else begin
              res_end_nxt = 1'b0;
              if (stat.adv_kind == ADV_NEED)      res_st_nxt = ST_NEED;
              else if (stat.adv_kind == ADV_END)  res_st_nxt = ST_END;
              else                                res_st_nxt = ST_ERR;
            end
          end
        endcase
      end
      S_RD1: begin
        cmd.op    = OP_RD1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.op    = OP_RD2;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        if (!stat.walk_done) begin
          state_nxt = S_WALK2;
        end else if (look_r) begin
          res_st_nxt  = ST_OK;
          res_end_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_WALK2: begin
        cmd.op    = OP_WALK2;
        state_nxt = S_WALK;
      end
      S_POP: begin
        cmd.op    = OP_POP;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        cmd.op = OP_POP2;
        if (stat.stack_empty) begin
          look_nxt  = 1'b1;
          state_nxt = S_ADV;
        end else begin
          res_st_nxt  = ST_OK;
          res_end_nxt = 1'b0;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        // Load the result register once it is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          oend_nxt  = res_end_r;
          obyte_nxt = (res_st_r == ST_OK) ? stat.byte_val : 8'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    look_r    <= look_nxt;
    res_st_r  <= res_st_nxt;
    res_end_r <= res_end_nxt;
    ost_r     <= ost_nxt;
    oend_r    <= oend_nxt;
    obyte_r   <= obyte_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_end    = oend_r;
  assign out_byte   = obyte_r;

endmodule

// ----- src/lzw_variable_width_decoder.sv -----
// Top level of the TIFF-style LZW decoder: controller plus datapath.
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_dp.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid in_ready in_func in_byte in_last | in
//  result  | out_valid out_ready out_byte out_status out_end | out
//
// A byte push is taken in the idle state. A request served from the stack
// steps through accept, pop, stack read and result load. On an empty stack a
// code is decoded first: each code is taken in the advance state (a clear code
// loops back to it), an added entry needs the two dictionary read steps, and
// the prefix-chain walk alternates between its two walk states. Popping the
// last byte of a string decodes the next code the same way before loading.
// Reset is synchronous and active low; the dictionary is not cleared.
// A result waits in the output register; pushes are still taken meanwhile,
// a further request stalls until the result is loaded.
module lzw_variable_width_decoder import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_end
);

  lzwd_cmd_t  cmd;
  lzwd_stat_t stat;

  lzwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_end    (out_end),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzwd_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_byte),
    .in_last (in_last),
    .stat    (stat)
  );

endmodule
